// ===== rtl/core/ifd_pkg.sv =====
// ----------------------------------------------------------------------------
// ifd_pkg
// shared types and constants of the interleaved frame deframer
// ----------------------------------------------------------------------------
package ifd_pkg;

    // frame marker and well-known channel numbers
    localparam logic [7:0] MARKER_BYTE = 8'h24;
    localparam logic [7:0] CHAN_VIDEO  = 8'd0;
    localparam logic [7:0] CHAN_AUDIO  = 8'd2;

    // configuration register indexes
    localparam logic [1:0] REG_VIDEO_ENABLE    = 2'd0;
    localparam logic [1:0] REG_AUDIO_ENABLE    = 2'd1;
    localparam logic [1:0] REG_MIN_CONTROL_LEN = 2'd2;

    localparam logic [15:0] MIN_CONTROL_LEN_RESET = 16'd28;

    // frame kind codes
    localparam logic [1:0] KIND_VIDEO   = 2'd0;
    localparam logic [1:0] KIND_AUDIO   = 2'd1;
    localparam logic [1:0] KIND_CONTROL = 2'd2;

    // one result item
    typedef struct packed {
        logic [7:0] payload_byte;
        logic [7:0] frame_channel;
        logic [1:0] frame_kind;
        logic       first_flag;
        logic       last_flag;
        logic       empty_frame;
    } t_result;

    function automatic logic [1:0] kind_of(input logic [7:0] ch);
        logic [1:0] k;
        if (ch == CHAN_VIDEO) begin
            k = KIND_VIDEO;
        end else if (ch == CHAN_AUDIO) begin
            k = KIND_AUDIO;
        end else begin
            k = KIND_CONTROL;
        end
        return k;
    endfunction

endpackage

// ===== rtl/core/interleaved_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// interleaved_frame_deframer
// byte-wise deframer for interleaved binary frames on a stream link
// ----------------------------------------------------------------------------
// One received byte is taken per transfer, one per clock cycle at full rate;
// each byte is parsed in the cycle it is accepted and any result it causes
// is registered in the output buffer. The rate is set by the single header
// and payload state machine, which updates once per byte. A two-entry output
// buffer (result register plus skid register) holds results, so input keeps
// flowing while one result waits; input stalls only when both are full.
// Frames are '$', channel, length high, length low, then payload. Channel 0
// (video) and channel 2 (audio) are kept when enabled; other channels are
// control and kept when the length reaches min_control_len. The keep
// decision is taken at the low length byte. A kept empty frame yields one
// result with first, last and empty flags set and a zero payload byte.
// Configuration writes are always taken; index 3 is ignored.
// ----------------------------------------------------------------------------
module interleaved_frame_deframer
    import ifd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_byte_in,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_payload_byte,
    output logic [7:0]  o_frame_channel,
    output logic [1:0]  o_frame_kind,
    output logic        o_first_flag,
    output logic        o_last_flag,
    output logic        o_empty_frame,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // parser phases, one-hot
    typedef enum logic [4:0] {
        PH_HUNT = 5'b00001,
        PH_CHAN = 5'b00010,
        PH_LENH = 5'b00100,
        PH_LENL = 5'b01000,
        PH_DATA = 5'b10000
    } t_phase;

    // configuration registers
    logic        r_video_enable;
    logic        r_audio_enable;
    logic [15:0] r_min_control_len;

    // parser state
    t_phase      r_phase,        n_phase;
    logic [7:0]  r_held_channel, n_held_channel;
    logic [7:0]  r_length_high,  n_length_high;
    logic [15:0] r_bytes_left,   n_bytes_left;
    logic        r_frame_kept,   n_frame_kept;
    logic        r_at_first,     n_at_first;

    logic        in_xfer;
    logic        push;
    t_result     res;
    t_result     out_res;
    logic        buf_space;
    logic [15:0] len;
    logic        keep;
    logic        last;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = buf_space;
    assign in_xfer     = i_in_valid && buf_space;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_video_enable    <= 1'b0;
            r_audio_enable    <= 1'b0;
            r_min_control_len <= MIN_CONTROL_LEN_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_VIDEO_ENABLE:    r_video_enable    <= i_cfg_data[0];
                REG_AUDIO_ENABLE:    r_audio_enable    <= i_cfg_data[0];
                REG_MIN_CONTROL_LEN: r_min_control_len <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // frame length and keep decision for the low length byte
    assign len = {r_length_high, i_byte_in};
    always_comb begin
        if (r_held_channel == CHAN_VIDEO) begin
            keep = r_video_enable;
        end else if (r_held_channel == CHAN_AUDIO) begin
            keep = r_audio_enable;
        end else begin
            keep = (len >= r_min_control_len);
        end
    end

    // payload byte closes the frame when one or none is left
    assign last = (r_bytes_left <= 16'd1);

    // next-state and result logic for one accepted byte
    always_comb begin
        n_phase        = r_phase;
        n_held_channel = r_held_channel;
        n_length_high  = r_length_high;
        n_bytes_left   = r_bytes_left;
        n_frame_kept   = r_frame_kept;
        n_at_first     = r_at_first;
        push           = 1'b0;
        res.payload_byte  = i_byte_in;
        res.frame_channel = r_held_channel;
        res.frame_kind    = kind_of(r_held_channel);
        res.first_flag    = r_at_first;
        res.last_flag     = last;
        res.empty_frame   = 1'b0;
        case (r_phase)
            PH_CHAN: begin
                n_held_channel = i_byte_in;
                n_phase        = PH_LENH;
            end
            PH_LENH: begin
                n_length_high = i_byte_in;
                n_phase       = PH_LENL;
            end
            PH_LENL: begin
                n_frame_kept = keep;
                n_bytes_left = len;
                n_at_first   = 1'b1;
                if (len == 16'd0) begin
                    // empty frame: one flagged result if kept
                    n_phase          = PH_HUNT;
                    push             = keep;
                    res.payload_byte = 8'd0;
                    res.first_flag   = 1'b1;
                    res.last_flag    = 1'b1;
                    res.empty_frame  = 1'b1;
                end else begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                if (last) begin
                    n_bytes_left = 16'd0;
                    n_phase      = PH_HUNT;
                end else begin
                    n_bytes_left = r_bytes_left - 16'd1;
                end
                if (r_frame_kept) begin
                    push       = 1'b1;
                    n_at_first = last;
                end
            end
            default: begin
                // hunting, also any unused phase code: resync on marker
                n_phase = (i_byte_in == MARKER_BYTE) ? PH_CHAN : PH_HUNT;
            end
        endcase
    end

    // parser state registers, advance only on an input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HUNT;
            r_held_channel <= 8'd0;
            r_length_high  <= 8'd0;
            r_bytes_left   <= 16'd0;
            r_frame_kept   <= 1'b0;
            r_at_first     <= 1'b1;
        end else if (in_xfer) begin
            r_phase        <= n_phase;
            r_held_channel <= n_held_channel;
            r_length_high  <= n_length_high;
            r_bytes_left   <= n_bytes_left;
            r_frame_kept   <= n_frame_kept;
            r_at_first     <= n_at_first;
        end
    end

    // result register with skid
    ifd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_xfer && push),
        .i_data  (res),
        .o_space (buf_space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_res)
    );

    assign o_payload_byte  = out_res.payload_byte;
    assign o_frame_channel = out_res.frame_channel;
    assign o_frame_kind    = out_res.frame_kind;
    assign o_first_flag    = out_res.first_flag;
    assign o_last_flag     = out_res.last_flag;
    assign o_empty_frame   = out_res.empty_frame;

endmodule

// ===== rtl/core/ifd_out_buf.sv =====
// ----------------------------------------------------------------------------
// ifd_out_buf
// two-entry output buffer: result register plus skid register
// ----------------------------------------------------------------------------
module ifd_out_buf
    import ifd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign pop     = r_main_valid && i_ready;
    assign o_space = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            if (r_main_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
            end else if (i_push) begin
                r_main <= i_data;
            end
        end else if (i_push) begin
            if (r_main_valid) begin
                r_skid <= i_data;
            end else begin
                r_main <= i_data;
            end
        end
    end

endmodule
